FILE: sv/ped_pkg.sv
package ped_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int INDEX_BITS  = 16;
   localparam int LEVEL_BITS  = 16;

   // Q8.8 level against a signed sample: one extra bit for the unsigned level
   localparam int PROD_BITS   = SAMPLE_BITS + LEVEL_BITS + 1;
   localparam int FRAC_BITS   = 8;

   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((INDEX_BITS + SAMPLE_BITS + 7) / 8) * 8;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = LEVEL_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL_RATIO = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIND_MINIMA = CSR_INDEX_BITS'(1);

   localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = LEVEL_BITS'(128);

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef struct packed {
      logic                   eos;
      logic [SAMPLE_BITS-1:0] sample;
   } ped_item_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] value;
      logic [INDEX_BITS-1:0]  index;
   } ped_peak_type;

   typedef struct packed {
      logic                  step;
      logic                  clear;
      logic                  find_minima;
      logic [LEVEL_BITS-1:0] level;
   } ped_ctrl_type;

endpackage

FILE: sv/periodic_extreme_detector.sv
// Path: the closing req beat enters the input register, then its peak beat the result register.
// Throughput: one req beat per cycle unless the result register stalls; the path from input
//   register to result register holds one 17x16 multiply between two compares, which set the rate.
// Backpressure: a stalled result register holds the input register, which then holds req.
// Reset: synchronous, active high; clears the valid flags of both pipeline registers, loads
//   level_ratio = 128, selects max mode and returns tracking state to its start values.
module periodic_extreme_detector (
   input  logic                                 clock,
   input  logic                                 reset,

   // sample stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ped_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // [15:0] sample
   input  logic                                 req_tlast,  // end_of_signal

   // peak stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ped_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // [15:0] peak_index, [31:16] peak_value

   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ped_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ped_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   logic [ped_pkg::LEVEL_BITS-1:0] level_ratio_ff, level_ratio_in;
   logic                           find_minima_ff, find_minima_in;
   logic                           csr_write;
   logic                           mode_write;

   ped_pkg::ped_item_type in_item;
   ped_pkg::ped_item_type item;
   ped_pkg::ped_ctrl_type ctrl;
   ped_pkg::ped_peak_type peak;
   logic                  step;
   logic                  emit;
   logic                  out_free;

   // Registers are always writable; the user must write only while the stream is idle, not enforced by the block.
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid & csr_ready;
   assign mode_write = csr_write & (csr_index == ped_pkg::CSR_FIND_MINIMA);

   always_comb begin
      level_ratio_in = level_ratio_ff;
      find_minima_in = find_minima_ff;
      if (csr_write) begin
         case (csr_index)
            ped_pkg::CSR_LEVEL_RATIO: begin
               level_ratio_in = csr_data;
            end
            ped_pkg::CSR_FIND_MINIMA: begin
               find_minima_in = csr_data[0];
            end
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ratio_ff <= ped_pkg::LEVEL_RESET;
         find_minima_ff <= 1'b0;
      end else begin
         level_ratio_ff <= level_ratio_in;
         find_minima_ff <= find_minima_in;
      end
   end

   assign in_item.sample = req_tdata[ped_pkg::SAMPLE_BITS-1:0];
   assign in_item.eos    = req_tlast;

   // Input register: hold the accepted beat until the result side has room.
   ped_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .out_free (out_free),
      .step     (step),
      .item     (item)
   );

   // A mode write restarts tracking with the start values of the new mode; the tracker
   // sees the new mode only once find_minima_ff holds it, so clear with the incoming value.
   assign ctrl.step        = step;
   assign ctrl.clear       = mode_write;
   assign ctrl.find_minima = mode_write ? find_minima_in : find_minima_ff;
   assign ctrl.level       = level_ratio_ff;

   // Tracker: update global and local extremes, test the threshold, flag a closed region.
   ped_track u_track (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .item  (item),
      .emit  (emit),
      .peak  (peak)
   );

   // Result register: advance a peak beat only when a region closes.
   ped_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .peak      (peak),
      .out_free  (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled while result side has room");

   a_emit_only_on_step: assert property (@(posedge clock) disable iff (reset)
      emit |-> (step && out_free))
      else $error("peak produced without an advancing beat");

   a_mode_write_clears: assert property (@(posedge clock) disable iff (reset)
      mode_write |=> (find_minima_ff == $past(csr_data[0])))
      else $error("mode write lost");

endmodule

FILE: sv/ped_in_reg.sv
module ped_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ped_pkg::ped_item_type in_item,
   input  logic                  out_free,
   output logic                  step,
   output ped_pkg::ped_item_type item
);

   logic                  valid_ff;
   logic                  valid_in;
   ped_pkg::ped_item_type item_ff;
   logic                  accept;

   assign step     = valid_ff & out_free;
   assign in_ready = ~valid_ff | out_free;
   assign accept   = in_valid & in_ready;
   assign item     = item_ff;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= in_item;
      end
   end

endmodule

FILE: sv/ped_track.sv
module ped_track (
   input  logic                  clock,
   input  logic                  reset,
   input  ped_pkg::ped_ctrl_type ctrl,
   input  ped_pkg::ped_item_type item,
   output logic                  emit,
   output ped_pkg::ped_peak_type peak
);

   logic signed [ped_pkg::SAMPLE_BITS-1:0] global_ff, global_in;
   logic signed [ped_pkg::SAMPLE_BITS-1:0] local_ff, local_in;
   logic [ped_pkg::INDEX_BITS-1:0]         local_index_ff, local_index_in;
   logic [ped_pkg::INDEX_BITS-1:0]         count_ff, count_in;
   logic                                   in_region_ff, in_region_in;

   logic signed [ped_pkg::SAMPLE_BITS-1:0] s;
   logic signed [ped_pkg::SAMPLE_BITS-1:0] start_value;
   logic signed [ped_pkg::SAMPLE_BITS-1:0] global_upd;
   logic signed [ped_pkg::SAMPLE_BITS-1:0] local_upd;
   logic [ped_pkg::INDEX_BITS-1:0]         local_index_upd;
   logic signed [ped_pkg::SAMPLE_BITS-1:0] mul_operand;
   logic signed [ped_pkg::SAMPLE_BITS-1:0] scaled_operand;
   logic signed [ped_pkg::PROD_BITS-1:0]   level_s;
   logic signed [ped_pkg::PROD_BITS-1:0]   product;
   logic signed [ped_pkg::PROD_BITS-1:0]   scaled;
   logic                                   beyond_global;
   logic                                   beyond_local;
   logic                                   in_band;

   assign s           = $signed(item.sample);
   assign start_value = ctrl.find_minima ? ped_pkg::SAMPLE_MAX : ped_pkg::SAMPLE_MIN;

   always_comb begin
      beyond_global = ctrl.find_minima ? (s < global_ff) : (s > global_ff);
      beyond_local  = ctrl.find_minima ? (s < local_ff) : (s > local_ff);
      global_upd    = beyond_global ? s : global_ff;
      local_upd       = beyond_local ? s : local_ff;
      local_index_upd = beyond_local ? count_ff : local_index_ff;

      // Both modes reduce to product < scaled:
      //   max: level * global < sample << 8
      //   min: sample * level < global << 8
      mul_operand    = ctrl.find_minima ? s : global_upd;
      scaled_operand = ctrl.find_minima ? global_upd : s;
      level_s        = $signed({{(ped_pkg::PROD_BITS-ped_pkg::LEVEL_BITS){1'b0}}, ctrl.level});
      product        = level_s * ped_pkg::PROD_BITS'(mul_operand);
      scaled         = ped_pkg::PROD_BITS'(scaled_operand) <<< ped_pkg::FRAC_BITS;
      in_band        = product < scaled;
      emit           = ctrl.step & ~in_band & in_region_ff;
   end

   assign peak.index = local_index_ff == local_index_upd ? local_index_ff : local_index_upd;
   assign peak.value = local_upd;

   always_comb begin
      global_in      = global_ff;
      local_in       = local_ff;
      local_index_in = local_index_ff;
      in_region_in   = in_region_ff;
      count_in       = count_ff;
      if (ctrl.clear || (ctrl.step && item.eos)) begin
         global_in      = start_value;
         local_in       = start_value;
         local_index_in = '0;
         in_region_in   = 1'b0;
         count_in       = '0;
      end else if (ctrl.step) begin
         global_in = global_upd;
         count_in  = count_ff + 1'b1;
         if (in_band) begin
            local_in       = local_upd;
            local_index_in = local_index_upd;
            in_region_in   = 1'b1;
         end else if (in_region_ff) begin
            // restart the local tracker at the sample that left the region
            local_in       = s;
            local_index_in = count_ff;
            in_region_in   = 1'b0;
         end else begin
            local_in       = local_upd;
            local_index_in = local_index_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         global_ff      <= ped_pkg::SAMPLE_MIN;
         local_ff       <= ped_pkg::SAMPLE_MIN;
         local_index_ff <= '0;
         in_region_ff   <= 1'b0;
         count_ff       <= '0;
      end else begin
         global_ff      <= global_in;
         local_ff       <= local_in;
         local_index_ff <= local_index_in;
         in_region_ff   <= in_region_in;
         count_ff       <= count_in;
      end
   end

   // the local extreme never lies beyond the global one; a mode write flips the
   // compare sense before the state is restarted, so skip that edge
   a_local_within_global: assert property (@(posedge clock) disable iff (reset)
      !ctrl.clear |->
         (ctrl.find_minima ? (local_ff >= global_ff) : (local_ff <= global_ff)))
      else $error("local extreme beyond global extreme");

   a_emit_needs_region: assert property (@(posedge clock) disable iff (reset)
      emit |-> in_region_ff)
      else $error("peak emitted outside a region");

   a_eos_restarts_count: assert property (@(posedge clock) disable iff (reset)
      (ctrl.step && item.eos) |=> (count_ff == '0 && !in_region_ff))
      else $error("end of signal did not clear tracking");

   a_emit_clears_region: assert property (@(posedge clock) disable iff (reset)
      (emit && !ctrl.clear) |=> !in_region_ff)
      else $error("region still open after peak emitted");

endmodule

FILE: sv/ped_out_reg.sv
module ped_out_reg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  ped_pkg::ped_peak_type               peak,
   output logic                                out_free,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [ped_pkg::RSP_DATA_BITS-1:0]   out_data
);

   logic                  valid_ff;
   logic                  valid_in;
   ped_pkg::ped_peak_type peak_ff;

   assign out_free  = ~valid_ff | out_ready;
   assign out_valid = valid_ff;
   assign out_data  = ped_pkg::RSP_DATA_BITS'(peak_ff);

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         peak_ff <= peak;
      end
   end

endmodule

FILE: tb/tb_periodic_extreme_detector.sv
module tb_periodic_extreme_detector;

   // Cycles without any accepted beat before the run is declared hung.
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   // A peak beat trails its closing sample through the input and result registers; leave some margin.
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned PHASE_ITEMS    = 100;
   localparam int unsigned PHASE_COUNT    = 8;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;

   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [ped_pkg::REQ_DATA_BITS-1:0]  req_tdata  = '0;  // [15:0] sample
   logic                               req_tlast  = 1'b0; // end_of_signal

   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [ped_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;  // [15:0] peak_index, [31:16] peak_value

   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [ped_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [ped_pkg::CSR_DATA_BITS-1:0]  csr_data  = '0;

   periodic_extreme_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Samples waiting for the driver, and peaks the tracker has predicted.
   ped_pkg::ped_item_type sample_queue[$];
   ped_pkg::ped_peak_type pending_peaks[$];

   // Handshake flags captured at each rising edge, read at the next falling edge.
   logic req_seen = 1'b0;
   logic rsp_seen = 1'b0;
   logic csr_seen = 1'b0;

   // Mirror of the detector: configuration and tracking state at block widths.
   logic [ped_pkg::LEVEL_BITS-1:0]         level_q88;
   logic                                   minima_mode;
   logic signed [ped_pkg::SAMPLE_BITS-1:0] global_ext;
   logic signed [ped_pkg::SAMPLE_BITS-1:0] local_ext;
   logic [ped_pkg::INDEX_BITS-1:0]         local_idx;
   logic [ped_pkg::INDEX_BITS-1:0]         sample_idx;
   logic                                   in_peak;

   int unsigned mismatch_count = 0;
   int unsigned idle_cycles    = 0;
   int unsigned queued_items   = 0;
   int unsigned samples_in     = 0;
   int unsigned peaks_checked  = 0;
   int unsigned csr_writes     = 0;
   int unsigned signal_ends    = 0;
   int unsigned burst_left     = 0;
   int unsigned gap_left       = 0;
   int unsigned ready_run      = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch @%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Return the extremes, both indexes and the region flag to their start values for the current mode.
   task automatic restart_tracking();
      global_ext = minima_mode ? ped_pkg::SAMPLE_MAX : ped_pkg::SAMPLE_MIN;
      local_ext  = global_ext;
      local_idx  = '0;
      sample_idx = '0;
      in_peak    = 1'b0;
   endtask

   // Advance the tracker by one sample and queue the peak it closes, if any.
   task automatic track_extreme(input logic signed [ped_pkg::SAMPLE_BITS-1:0] s,
                                input logic last);
      logic                  in_band;
      ped_pkg::ped_peak_type pk;
      if (minima_mode) begin
         if (s < global_ext) global_ext = s;
         if (s < local_ext) begin
            local_ext = s;
            local_idx = sample_idx;
         end
         // cross-multiplied: s * level < global * 1.0, level in Q8.8
         in_band = (longint'(s) * longint'(level_q88)) < (longint'(global_ext) * 256);
      end else begin
         if (s > global_ext) global_ext = s;
         if (s > local_ext) begin
            local_ext = s;
            local_idx = sample_idx;
         end
         in_band = (longint'(s) * 256) > (longint'(level_q88) * longint'(global_ext));
      end
      if (in_band) begin
         in_peak = 1'b1;
      end else if (in_peak) begin
         pk.index = local_idx;
         pk.value = local_ext;
         pending_peaks.push_back(pk);
         in_peak   = 1'b0;
         local_ext = s;
         local_idx = sample_idx;
      end
      sample_idx = sample_idx + 1'b1;
      // a peak closed on the final sample is already queued; drop the rest
      if (last) restart_tracking();
   endtask

   // Monitor: sample every handshake at the rising edge, compare peaks first so a
   // peak predicted on this same edge never pairs with an older beat.
   always @(posedge clock) begin : monitor
      ped_pkg::ped_peak_type got;
      ped_pkg::ped_peak_type want;
      if (reset) begin
         req_seen    = 1'b0;
         rsp_seen    = 1'b0;
         csr_seen    = 1'b0;
         level_q88   = ped_pkg::LEVEL_RESET;
         minima_mode = 1'b0;
         restart_tracking();
         idle_cycles = 0;
      end else begin
         req_seen = req_tvalid && req_tready;
         rsp_seen = rsp_tvalid && rsp_tready;
         csr_seen = csr_valid && csr_ready;
         if (csr_seen) begin
            csr_writes++;
            if (csr_index == ped_pkg::CSR_LEVEL_RATIO) begin
               level_q88 = csr_data;
            end else if (csr_index == ped_pkg::CSR_FIND_MINIMA) begin
               // any mode write restarts tracking, even with an unchanged mode
               minima_mode = csr_data[0];
               restart_tracking();
            end
         end
         if (rsp_seen) begin
            got = ped_pkg::ped_peak_type'(rsp_tdata);
            if (pending_peaks.size() == 0) begin
               report_mismatch($sformatf("unexpected peak beat index %0d value %0d",
                                         got.index, $signed(got.value)));
            end else begin
               want = pending_peaks.pop_front();
               if (got.index !== want.index)
                  report_mismatch($sformatf("peak_index %0d, expected %0d",
                                            got.index, want.index));
               if (got.value !== want.value)
                  report_mismatch($sformatf("peak_value %0d, expected %0d",
                                            $signed(got.value), $signed(want.value)));
               peaks_checked++;
            end
         end
         if (req_seen) begin
            track_extreme(req_tdata[ped_pkg::SAMPLE_BITS-1:0], req_tlast);
            samples_in++;
            if (req_tlast) signal_ends++;
         end
         if (req_seen || rsp_seen || csr_seen) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no beat for %0d cycles, %0d peaks outstanding",
                        idle_cycles, pending_peaks.size());
               $display("periodic_extreme_detector regression: fail");
               $finish;
            end
         end
      end
   end

   // Driver: present samples in bursts with random gaps; hold an unaccepted beat.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_seen) sample_queue.delete(0);
         if (req_tvalid && !req_seen) begin
            // hold the beat until the block takes it
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (sample_queue.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= ped_pkg::REQ_DATA_BITS'(sample_queue[0].sample);
            req_tlast  <= sample_queue[0].eos;
            if (burst_left == 0) begin
               burst_left = $urandom_range(0, 40);
               // one burst in four runs straight into the next
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: alternate ready runs and stall runs, with an occasional long ready run.
   always @(negedge clock) begin
      if (ready_run == 0) begin
         if (rsp_tready) begin
            rsp_tready <= 1'b0;
            ready_run = $urandom_range(1, 10);
         end else begin
            rsp_tready <= 1'b1;
            ready_run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 30);
         end
      end else begin
         ready_run--;
      end
   end

   task automatic queue_item(input logic [ped_pkg::SAMPLE_BITS-1:0] s, input logic last);
      ped_pkg::ped_item_type it;
      it.sample = s;
      it.eos    = last;
      sample_queue.push_back(it);
      queued_items++;
   endtask

   // Queue a noisy triangle wave; the last sample carries end_of_signal if asked.
   task automatic queue_signal(input int period, input int amp, input int offs,
                               input int noise, input int unsigned len, input bit last);
      int tri_pos;
      int v;
      for (int unsigned i = 0; i < len; i++) begin
         tri_pos = int'(i % period);
         if (tri_pos >= period / 2) tri_pos = period - tri_pos;
         v = offs + (2 * tri_pos * amp) / period - amp / 2
             + int'($urandom_range(0, 2 * noise)) - noise;
         if (v > int'(ped_pkg::SAMPLE_MAX)) v = int'(ped_pkg::SAMPLE_MAX);
         if (v < int'(ped_pkg::SAMPLE_MIN)) v = int'(ped_pkg::SAMPLE_MIN);
         queue_item(ped_pkg::SAMPLE_BITS'(v), last && (i == len - 1));
      end
   endtask

   // Mostly well-formed waveforms; some raw full-range noise and unterminated runs.
   task automatic queue_random_mix(input int unsigned n_items);
      int unsigned target;
      target = queued_items + n_items;
      while (queued_items < target) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6))
               queue_item(ped_pkg::SAMPLE_BITS'($urandom), $urandom_range(0, 7) == 0);
         end else begin
            queue_signal($urandom_range(3, 40),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(30000, 65535)
                                                     : $urandom_range(0, 20000),
                         int'($urandom_range(0, 50000)) - 25000,
                         $urandom_range(0, 300),
                         ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 40),
                         $urandom_range(0, 7) != 0);
         end
      end
   endtask

   // Drain: all samples taken, every predicted peak seen, pipeline settled.
   task automatic wait_idle();
      while (sample_queue.size() != 0 || req_tvalid || pending_peaks.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Call at a falling edge; leaves csr_valid high so writes can follow back to back.
   task automatic write_csr(input logic [ped_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [ped_pkg::CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(negedge clock); while (!csr_seen);
   endtask

   initial begin : stimulus
      int unsigned phase_level[PHASE_COUNT] = '{65535, 1, 0, 0, 65535, 256, 320, 128};
      bit          phase_mode[PHASE_COUNT]  = '{0, 1, 0, 1, 1, 0, 1, 0};
      bit          cur_mode;
      int unsigned lvl;
      bit          md;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed, at reset settings (max mode, level one half).
      // Peak closed mid-signal, then a peak closed by the final sample.
      queue_item(ped_pkg::SAMPLE_MIN, 1'b0);
      queue_item(16'sd100, 1'b0);
      queue_item(16'sd40, 1'b0);
      queue_item(ped_pkg::SAMPLE_MAX, 1'b0);
      queue_item(16'sd0, 1'b1);
      // Region still open at the end: nothing comes out.
      queue_item(16'sd5, 1'b0);
      queue_item(16'sd10, 1'b1);
      // Repeated maximum keeps the first index; all-negative start never enters.
      queue_item(-16'sd1, 1'b0);
      queue_item(-16'sd2, 1'b0);
      queue_item(ped_pkg::SAMPLE_MAX, 1'b0);
      queue_item(ped_pkg::SAMPLE_MAX, 1'b0);
      queue_item(ped_pkg::SAMPLE_MIN, 1'b0);
      queue_item(16'sd1, 1'b1);
      wait_idle();

      // Directed valleys in min mode; upper data bits of the mode write are ignored.
      write_csr(ped_pkg::CSR_FIND_MINIMA, {(ped_pkg::CSR_DATA_BITS-1)'($urandom), 1'b1});
      csr_valid <= 1'b0;
      cur_mode = 1'b1;
      queue_item(16'sd1000, 1'b0);
      queue_item(16'sd3000, 1'b0);
      queue_item(16'sd1500, 1'b1);
      queue_item(ped_pkg::SAMPLE_MAX, 1'b0);
      queue_item(ped_pkg::SAMPLE_MIN, 1'b0);
      queue_item(16'sd0, 1'b1);
      wait_idle();

      // Random phases across level extremes (zero and full scale included) and modes.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         lvl = phase_level[p];
         md  = phase_mode[p];
         if (p >= 6) begin
            lvl = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 1024)
                                              : $urandom_range(0, 65535);
            md  = $urandom_range(0, 1);
         end
         write_csr(ped_pkg::CSR_LEVEL_RATIO, ped_pkg::CSR_DATA_BITS'(lvl));
         // Skip the mode write now and then so tracking carries across the level change.
         if (md != cur_mode || $urandom_range(0, 1) == 0)
            write_csr(ped_pkg::CSR_FIND_MINIMA,
                      {(ped_pkg::CSR_DATA_BITS-1)'($urandom), md});
         if (p == 0)
            write_csr('1, '1);
         else if ($urandom_range(0, 2) == 0)
            write_csr(ped_pkg::CSR_INDEX_BITS'(
                         $urandom_range(int'(ped_pkg::CSR_FIND_MINIMA) + 1,
                                        (1 << ped_pkg::CSR_INDEX_BITS) - 1)),
                      ped_pkg::CSR_DATA_BITS'($urandom));
         csr_valid <= 1'b0;
         cur_mode = md;
         queue_random_mix(PHASE_ITEMS);
         wait_idle();
      end

      $display("covered %0d samples over %0d signal ends, %0d register writes",
               samples_in, signal_ends, csr_writes);
      $display("checked %0d peaks in both modes, zero to full-scale level",
               peaks_checked);
      if (mismatch_count == 0) begin
         $display("periodic_extreme_detector regression: pass");
      end else begin
         $display("periodic_extreme_detector regression: fail");
      end
      $finish;
   end

endmodule

FILE: periodic_extreme_detector.f
sv/ped_pkg.sv
sv/ped_in_reg.sv
sv/ped_track.sv
sv/ped_out_reg.sv
sv/periodic_extreme_detector.sv
tb/tb_periodic_extreme_detector.sv
